### hdl/pds_pkg.sv
// shared types and constants of the primitive depth sorter
package pds_pkg;

	// request codes
	localparam logic [2:0] OP_PUSH_DEPTH = 3'd0;
	localparam logic [2:0] OP_PUSH_INDEX = 3'd1;
	localparam logic [2:0] OP_SORT       = 3'd2;
	localparam logic [2:0] OP_READ       = 3'd3;
	localparam logic [2:0] OP_CLEAR      = 3'd4;

	// result status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_RANGE = 2'd2;

	// reset value of the group size register
	localparam logic [2:0] GROUP_SIZE_RESET = 3'd3;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_K_START,
		S_K_IDX,
		S_K_DEP,
		S_K_CMP,
		S_M_BLK,
		S_M_RD,
		S_M_KEY,
		S_M_CMP,
		S_R_START,
		S_R_ORD,
		S_R_IDX,
		S_R_WR
	} state_t;

	// commands from controller to datapath
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_K_IDX,
		CMD_K_DEP,
		CMD_K_CMP,
		CMD_M_INIT,
		CMD_M_PASS,
		CMD_M_BLK,
		CMD_M_END,
		CMD_M_RD,
		CMD_M_KEY,
		CMD_M_CMP,
		CMD_R_INIT,
		CMD_R_ORD,
		CMD_R_IDX,
		CMD_R_WR,
		CMD_FLIP
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic k_more;
		logic m_sorted;
		logic m_pass_end;
		logic m_blk_end;
		logic r_more;
	} sts_t;

endpackage

### hdl/pds_datapath.sv
// datapath of the depth sorter: stores, counters, key, merge and rebuild steps
module pds_datapath #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_INDICES  = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               exec,
	input  pds_pkg::cmd_t      cmd,
	input  logic [2:0]         op,
	input  logic signed [31:0] vertex_depth,
	input  logic [9:0]         vertex_index,
	input  logic [10:0]        read_position,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_data,
	output pds_pkg::sts_t      sts,
	output logic               done,
	output logic [1:0]         status,
	output logic [9:0]         index_out,
	output logic [10:0]        assigned_slot
);

	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int VCW = VAW + 1;
	localparam int IAW = $clog2(MAX_INDICES);
	localparam int ICW = IAW + 1;
	localparam int SW  = ICW + 2;
	localparam int VXW = (VCW > 10) ? VCW : 10;
	localparam int PXW = (ICW > 11) ? ICW : 11;

	// configuration and counts
	logic [2:0]     ipp_q;
	logic [2:0]     gs;
	logic [VCW-1:0] vcount_q;
	logic [ICW-1:0] icount_q;
	logic           act_q;

	// memories and their read registers
	logic signed [31:0] depth_mem [MAX_VERTICES];
	logic [9:0]         idx_mem [2*MAX_INDICES];
	logic signed [31:0] key_mem [MAX_INDICES];
	logic [IAW-1:0]     ord_mem [2*MAX_INDICES];
	logic signed [31:0] dep_rd_q;
	logic [9:0]         idx_rd_q;
	logic signed [31:0] key_a_q, key_b_q;
	logic [IAW-1:0]     ord_a_q, ord_b_q;

	// sort counters
	logic [ICW-1:0]     kp_q, kbase_q;
	logic [1:0]         kk_q;
	logic signed [31:0] kmin_q;
	logic [ICW:0]       w_q, lo_q;
	logic [ICW-1:0]     a_q, b_q, o_q;
	logic               srcb_q;
	logic [ICW-1:0]     rq_q, rp_q;
	logic [1:0]         rk_q;

	// result registers
	logic       done_q;
	logic [1:0] status_q;
	logic [10:0] slot_q;
	logic       rd_ok_q;

	// decoded checks and addresses
	logic               v_full, i_full, vidx_bad, pos_bad;
	logic               grp_last;
	logic signed [31:0] kmin_nx;
	logic [SW-1:0]      lo_w, lo_2w, m_x;
	logic [ICW-1:0]     mid, hi;
	logic               take_a;
	logic [IAW+1:0]     prod;
	logic [IAW-1:0]     kaddr, raddr;
	logic               idx_re;
	logic [IAW:0]       idx_ra;

	// effective group size
	always_comb begin
		if (ipp_q == 3'd0) begin
			gs = 3'd1;
		end else if (ipp_q > 3'd4) begin
			gs = 3'd4;
		end else begin
			gs = ipp_q;
		end
	end

	// request checks
	assign v_full   = vcount_q >= VCW'(MAX_VERTICES);
	assign i_full   = icount_q >= ICW'(MAX_INDICES);
	assign vidx_bad = VXW'(vertex_index) >= VXW'(vcount_q);
	assign pos_bad  = PXW'(read_position) >= PXW'(icount_q);
	assign grp_last = kk_q == 2'(gs - 3'd1);

	// running minimum of a primitive
	assign kmin_nx = (kk_q == 2'd0 || dep_rd_q < kmin_q) ? dep_rd_q : kmin_q;

	// merge block bounds
	assign lo_w  = SW'(lo_q) + SW'(w_q);
	assign lo_2w = lo_w + SW'(w_q);
	assign m_x   = SW'(kp_q);
	assign mid   = ICW'((lo_w < m_x) ? lo_w : m_x);
	assign hi    = ICW'((lo_2w < m_x) ? lo_2w : m_x);
	assign take_a = (a_q < mid) && ((b_q >= hi) || (key_a_q <= key_b_q));

	// gather addresses
	assign kaddr = IAW'(kbase_q + ICW'(kk_q));
	assign prod  = (IAW+2)'(ord_a_q) * (IAW+2)'(gs) + (IAW+2)'(rk_q);
	assign raddr = (rq_q < kbase_q) ? IAW'(prod) : IAW'(rq_q);

	// status to controller
	assign sts.k_more     = ((ICW+1)'(kbase_q) + (ICW+1)'(gs)) <= (ICW+1)'(icount_q);
	assign sts.m_sorted   = SW'(w_q) >= m_x;
	assign sts.m_pass_end = SW'(lo_q) >= m_x;
	assign sts.m_blk_end  = o_q >= hi;
	assign sts.r_more     = rq_q < icount_q;

	// index store read port selection
	always_comb begin
		idx_re = 1'b0;
		idx_ra = {act_q, IAW'(read_position)};
		if (exec && op == pds_pkg::OP_READ) begin
			idx_re = 1'b1;
		end else if (cmd == pds_pkg::CMD_K_IDX) begin
			idx_re = 1'b1;
			idx_ra = {act_q, kaddr};
		end else if (cmd == pds_pkg::CMD_R_IDX) begin
			idx_re = 1'b1;
			idx_ra = {act_q, raddr};
		end
	end

	// depth store
	always_ff @(posedge clk) begin
		if (exec && op == pds_pkg::OP_PUSH_DEPTH && !v_full) begin
			depth_mem[VAW'(vcount_q)] <= vertex_depth;
		end
		if (cmd == pds_pkg::CMD_K_DEP) begin
			dep_rd_q <= depth_mem[VAW'(idx_rd_q)];
		end
	end

	// index store, two banks
	always_ff @(posedge clk) begin
		if (exec && op == pds_pkg::OP_PUSH_INDEX && !i_full && !vidx_bad) begin
			idx_mem[{act_q, IAW'(icount_q)}] <= vertex_index;
		end else if (cmd == pds_pkg::CMD_R_WR) begin
			idx_mem[{~act_q, IAW'(rq_q)}] <= idx_rd_q;
		end
		if (idx_re) begin
			idx_rd_q <= idx_mem[idx_ra];
		end
	end

	// primitive key store
	always_ff @(posedge clk) begin
		if (cmd == pds_pkg::CMD_K_CMP && grp_last) begin
			key_mem[IAW'(kp_q)] <= kmin_nx;
		end
		if (cmd == pds_pkg::CMD_M_KEY) begin
			key_a_q <= key_mem[ord_a_q];
			key_b_q <= key_mem[ord_b_q];
		end
	end

	// order store, two banks
	always_ff @(posedge clk) begin
		if (cmd == pds_pkg::CMD_K_CMP && grp_last) begin
			ord_mem[{1'b0, IAW'(kp_q)}] <= IAW'(kp_q);
		end else if (cmd == pds_pkg::CMD_M_CMP) begin
			ord_mem[{~srcb_q, IAW'(o_q)}] <= take_a ? ord_a_q : ord_b_q;
		end
		if (cmd == pds_pkg::CMD_M_RD) begin
			ord_a_q <= ord_mem[{srcb_q, IAW'(a_q)}];
			ord_b_q <= ord_mem[{srcb_q, IAW'(b_q)}];
		end else if (cmd == pds_pkg::CMD_R_ORD) begin
			ord_a_q <= ord_mem[{srcb_q, IAW'(rp_q)}];
		end
	end

	// configuration, counts and bank select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipp_q    <= pds_pkg::GROUP_SIZE_RESET;
			vcount_q <= '0;
			icount_q <= '0;
			act_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				ipp_q <= cfg_data;
			end
			if (exec) begin
				case (op)
					pds_pkg::OP_PUSH_DEPTH: begin
						if (!v_full) vcount_q <= vcount_q + VCW'(1);
					end
					pds_pkg::OP_PUSH_INDEX: begin
						if (!i_full && !vidx_bad) icount_q <= icount_q + ICW'(1);
					end
					pds_pkg::OP_CLEAR: begin
						vcount_q <= '0;
						icount_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd == pds_pkg::CMD_FLIP) begin
				act_q <= ~act_q;
			end
		end
	end

	// sort sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			kbase_q <= '0;
			kk_q    <= '0;
			w_q     <= '0;
			lo_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			o_q     <= '0;
			srcb_q  <= 1'b0;
			rq_q    <= '0;
			rp_q    <= '0;
			rk_q    <= '0;
		end else begin
			if (exec && op == pds_pkg::OP_SORT) begin
				kp_q    <= '0;
				kbase_q <= '0;
				kk_q    <= '0;
			end
			case (cmd)
				pds_pkg::CMD_K_CMP: begin
					if (grp_last) begin
						kk_q    <= '0;
						kp_q    <= kp_q + ICW'(1);
						kbase_q <= kbase_q + ICW'(gs);
					end else begin
						kk_q <= kk_q + 2'd1;
					end
				end
				pds_pkg::CMD_M_INIT: begin
					w_q    <= (ICW+1)'(1);
					lo_q   <= '0;
					srcb_q <= 1'b0;
				end
				pds_pkg::CMD_M_PASS: begin
					w_q    <= w_q << 1;
					lo_q   <= '0;
					srcb_q <= ~srcb_q;
				end
				pds_pkg::CMD_M_BLK: begin
					a_q <= ICW'(lo_q);
					b_q <= mid;
					o_q <= ICW'(lo_q);
				end
				pds_pkg::CMD_M_END: begin
					lo_q <= (ICW+1)'(lo_2w);
				end
				pds_pkg::CMD_M_CMP: begin
					if (take_a) a_q <= a_q + ICW'(1);
					else b_q <= b_q + ICW'(1);
					o_q <= o_q + ICW'(1);
				end
				pds_pkg::CMD_R_INIT: begin
					rq_q <= '0;
					rp_q <= '0;
					rk_q <= '0;
				end
				pds_pkg::CMD_R_WR: begin
					rq_q <= rq_q + ICW'(1);
					if (rk_q == 2'(gs - 3'd1)) begin
						rk_q <= '0;
						rp_q <= rp_q + ICW'(1);
					end else begin
						rk_q <= rk_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// running minimum register
	always_ff @(posedge clk) begin
		if (cmd == pds_pkg::CMD_K_CMP) begin
			kmin_q <= kmin_nx;
		end
	end

	// result strobe and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			status_q <= pds_pkg::STS_OK;
			slot_q   <= '0;
			rd_ok_q  <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			status_q <= pds_pkg::STS_OK;
			slot_q   <= '0;
			rd_ok_q  <= 1'b0;
			if (exec && op != pds_pkg::OP_SORT) begin
				done_q <= 1'b1;
				case (op)
					pds_pkg::OP_PUSH_DEPTH: begin
						if (v_full) status_q <= pds_pkg::STS_FULL;
						else slot_q <= 11'(vcount_q);
					end
					pds_pkg::OP_PUSH_INDEX: begin
						if (i_full) status_q <= pds_pkg::STS_FULL;
						else if (vidx_bad) status_q <= pds_pkg::STS_RANGE;
						else slot_q <= 11'(icount_q);
					end
					pds_pkg::OP_READ: begin
						if (pos_bad) status_q <= pds_pkg::STS_RANGE;
						else rd_ok_q <= 1'b1;
					end
					default: ;
				endcase
			end else if (cmd == pds_pkg::CMD_FLIP) begin
				done_q <= 1'b1;
			end
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign assigned_slot = slot_q;
	assign index_out     = rd_ok_q ? idx_rd_q : 10'd0;

`ifndef SYNTHESIS
	// counts never pass their store sizes
	a_vcount: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= VCW'(MAX_VERTICES)) else $error("vertex count overflow");
	a_icount: assert property (@(posedge clk) disable iff (!arst_n)
		icount_q <= ICW'(MAX_INDICES)) else $error("index count overflow");
	// a read result only follows an accepted read
	a_rdok: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ok_q |-> done_q && status_q == pds_pkg::STS_OK)
		else $error("read data without read result");
	// merge output index stays inside its block
	a_merge: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == pds_pkg::CMD_M_CMP |-> o_q < hi) else $error("merge ran past block");
`endif

endmodule

### hdl/pds_ctrl.sv
// controller state machine that sequences the sort of the depth sorter
module pds_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          is_sort,
	input  pds_pkg::sts_t sts,
	output pds_pkg::cmd_t cmd,
	output logic          busy
);

	pds_pkg::state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pds_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and command
	always_comb begin
		state_nx = state_q;
		cmd      = pds_pkg::CMD_NONE;
		unique case (state_q)
			pds_pkg::S_IDLE: begin
				if (accept && is_sort) state_nx = pds_pkg::S_K_START;
			end
			pds_pkg::S_K_START: begin
				if (sts.k_more) begin
					state_nx = pds_pkg::S_K_IDX;
				end else begin
					cmd      = pds_pkg::CMD_M_INIT;
					state_nx = pds_pkg::S_M_BLK;
				end
			end
			pds_pkg::S_K_IDX: begin
				cmd      = pds_pkg::CMD_K_IDX;
				state_nx = pds_pkg::S_K_DEP;
			end
			pds_pkg::S_K_DEP: begin
				cmd      = pds_pkg::CMD_K_DEP;
				state_nx = pds_pkg::S_K_CMP;
			end
			pds_pkg::S_K_CMP: begin
				cmd      = pds_pkg::CMD_K_CMP;
				state_nx = pds_pkg::S_K_START;
			end
			pds_pkg::S_M_BLK: begin
				if (sts.m_sorted) begin
					cmd      = pds_pkg::CMD_R_INIT;
					state_nx = pds_pkg::S_R_START;
				end else if (sts.m_pass_end) begin
					cmd = pds_pkg::CMD_M_PASS;
				end else begin
					cmd      = pds_pkg::CMD_M_BLK;
					state_nx = pds_pkg::S_M_RD;
				end
			end
			pds_pkg::S_M_RD: begin
				if (sts.m_blk_end) begin
					cmd      = pds_pkg::CMD_M_END;
					state_nx = pds_pkg::S_M_BLK;
				end else begin
					cmd      = pds_pkg::CMD_M_RD;
					state_nx = pds_pkg::S_M_KEY;
				end
			end
			pds_pkg::S_M_KEY: begin
				cmd      = pds_pkg::CMD_M_KEY;
				state_nx = pds_pkg::S_M_CMP;
			end
			pds_pkg::S_M_CMP: begin
				cmd      = pds_pkg::CMD_M_CMP;
				state_nx = pds_pkg::S_M_RD;
			end
			pds_pkg::S_R_START: begin
				if (sts.r_more) begin
					state_nx = pds_pkg::S_R_ORD;
				end else begin
					cmd      = pds_pkg::CMD_FLIP;
					state_nx = pds_pkg::S_IDLE;
				end
			end
			pds_pkg::S_R_ORD: begin
				cmd      = pds_pkg::CMD_R_ORD;
				state_nx = pds_pkg::S_R_IDX;
			end
			pds_pkg::S_R_IDX: begin
				cmd      = pds_pkg::CMD_R_IDX;
				state_nx = pds_pkg::S_R_WR;
			end
			pds_pkg::S_R_WR: begin
				cmd      = pds_pkg::CMD_R_WR;
				state_nx = pds_pkg::S_R_START;
			end
			default: begin
				state_nx = pds_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = state_q != pds_pkg::S_IDLE;

endmodule

### hdl/primitive_depth_sorter_unit.sv
// top level of the primitive depth sorter
// push, read, clear: one item a cycle while busy is low, result strobe in the next cycle
// sort: keys by index read, depth read and compare per grouped index; merge passes of read,
//   key read and compare per primitive (ceil(log2 primitives) passes); order, index read and write to rebuild
// busy holds new items off during a sort; the receiver cannot stall the result strobe
// reset clears the counts and sets the group size to 3; stores hold old contents
module primitive_depth_sorter_unit #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_INDICES  = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [31:0] vertex_depth,
	input  logic [9:0]         vertex_index,
	input  logic [10:0]        read_position,
	output logic               done,
	output logic [1:0]         status,
	output logic [9:0]         index_out,
	output logic [10:0]        assigned_slot,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_data
);

	logic          accept;
	pds_pkg::cmd_t cmd;
	pds_pkg::sts_t sts;

	// item and register handshakes
	assign accept    = start && !busy;
	assign cfg_ready = !busy;

	pds_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.is_sort (op == pds_pkg::OP_SORT),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy)
	);

	pds_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_INDICES  (MAX_INDICES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.exec          (accept),
		.cmd           (cmd),
		.op            (op),
		.vertex_depth  (vertex_depth),
		.vertex_index  (vertex_index),
		.read_position (read_position),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.sts           (sts),
		.done          (done),
		.status        (status),
		.index_out     (index_out),
		.assigned_slot (assigned_slot)
	);

endmodule
